// ===== rtl/toq_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-class oldest-first queue package
// Shared command, status and class codes, defaults and control and status structs.
// ----------------------------------------------------------------------------
package toq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_STAMP_BITS  = 16;
	localparam int ID_BITS         = 16;

	typedef enum logic [2:0] {
		CMD_ENQ_DOG = 3'd0,
		CMD_ENQ_CAT = 3'd1,
		CMD_DEQ_ANY = 3'd2,
		CMD_DEQ_DOG = 3'd3,
		CMD_DEQ_CAT = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_DOG  = 2'd1,
		CLS_CAT  = 2'd2
	} class_t;

	// Control into one chain of cells.
	typedef struct packed {
		logic push;
		logic pop;
	} chain_ctrl_t;

	// Status out of one chain of cells.
	typedef struct packed {
		logic empty;
		logic full;
	} chain_stat_t;

endpackage

// ===== rtl/toq_cell.sv =====
// ----------------------------------------------------------------------------
// Queue cell
// Holds one identifier and its arrival stamp; loads a new entry or takes the
// entry of its neighbour further from the head.
// ----------------------------------------------------------------------------
module toq_cell
	import toq_pkg::*;
#(
	parameter int STAMP_BITS = DEF_STAMP_BITS
) (
	input  logic                  clk,
	input  logic                  load_en,
	input  logic                  shift_en,
	input  logic [ID_BITS-1:0]    new_id,
	input  logic [STAMP_BITS-1:0] new_stamp,
	input  logic [ID_BITS-1:0]    next_id,
	input  logic [STAMP_BITS-1:0] next_stamp,
	output logic [ID_BITS-1:0]    id,
	output logic [STAMP_BITS-1:0] stamp
);

	logic [ID_BITS-1:0]    id_q;
	logic [STAMP_BITS-1:0] stamp_q;

	// A cell holds its entry when neither a shift nor a load is asked for.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			id_q    <= next_id;
			stamp_q <= next_stamp;
		end else if (load_en) begin
			id_q    <= new_id;
			stamp_q <= new_stamp;
		end
	end

	assign id    = id_q;
	assign stamp = stamp_q;

endmodule

// ===== rtl/toq_chain.sv =====
// ----------------------------------------------------------------------------
// Queue chain
// A row of cells forming one FIFO with its head always in cell zero, plus the
// fill count that selects the cell a push lands in.
// ----------------------------------------------------------------------------
module toq_chain
	import toq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  chain_ctrl_t           ctrl,
	input  logic [ID_BITS-1:0]    new_id,
	input  logic [STAMP_BITS-1:0] new_stamp,
	output logic [ID_BITS-1:0]    head_id,
	output logic [STAMP_BITS-1:0] head_stamp,
	output chain_stat_t           stat
);

	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_BITS-1:0]   count_q;
	logic [ID_BITS-1:0]    cell_id    [QUEUE_DEPTH];
	logic [STAMP_BITS-1:0] cell_stamp [QUEUE_DEPTH];

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_BITS'(QUEUE_DEPTH));

	// The caller only pushes when not full and only pops when not empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CNT_BITS'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - CNT_BITS'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ID_BITS-1:0]    nxt_id;
		logic [STAMP_BITS-1:0] nxt_stamp;

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt_id    = '0;
			assign nxt_stamp = '0;
		end else begin : g_mid
			assign nxt_id    = cell_id[i+1];
			assign nxt_stamp = cell_stamp[i+1];
		end

		toq_cell #(
			.STAMP_BITS(STAMP_BITS)
		) u_cell (
			.clk       (clk),
			.load_en   (ctrl.push && (count_q == CNT_BITS'(i))),
			.shift_en  (ctrl.pop),
			.new_id    (new_id),
			.new_stamp (new_stamp),
			.next_id   (nxt_id),
			.next_stamp(nxt_stamp),
			.id        (cell_id[i]),
			.stamp     (cell_stamp[i])
		);
	end

	assign head_id    = cell_id[0];
	assign head_stamp = cell_stamp[0];

endmodule

// ===== rtl/two_class_oldest_first_queue.sv =====
// ----------------------------------------------------------------------------
// Two-class oldest-first queue
// Two FIFOs of identifiers (dog and cat) with shared arrival stamps and a
// dequeue command that serves whichever class holds the older head.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries a command in s_tuser and an
// identifier in s_tdata, and yields exactly one result on the master stream.
// Both FIFOs are rows of cells with the head held in cell zero: a push writes
// the cell picked by the fill count and a pop moves every entry one cell
// towards the head, so the head entry and its stamp are always at hand. A
// request is taken when s_tvalid and s_tready are both high, and its result appears in the output
// register on the next edge; one request per cycle is sustained while the
// downstream side takes results, since the block accepts a new request
// whenever the output register is empty or being emptied in the same cycle.
// Every enqueue, stored or dropped, advances the shared arrival counter.
// Dequeue-any compares the two head stamps by modular difference: the dog is
// served when the difference has its top bit set, otherwise the cat, and a
// class that is empty is never chosen. Unused command codes leave the state
// alone and report success with no class.
// ----------------------------------------------------------------------------
module two_class_oldest_first_queue
	import toq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int STAMP_BITS  = DEF_STAMP_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] entry_id
	input  logic [2:0]  s_tuser,   // [2:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] served_id
	output logic [3:0]  m_tuser    // [1:0] status, [3:2] served_class
);

	chain_ctrl_t           dog_ctrl, cat_ctrl;
	chain_stat_t           dog_stat, cat_stat;
	logic [ID_BITS-1:0]    dog_id, cat_id;
	logic [STAMP_BITS-1:0] dog_stamp, cat_stamp, stamp_diff;
	logic [STAMP_BITS-1:0] arrival_q;

	logic                  take;
	logic                  enq;
	logic                  dog_older;
	cmd_t                  cmd;

	status_t               res_status;
	class_t                res_class;
	logic [ID_BITS-1:0]    res_id;

	logic                  out_valid_q;
	status_t               status_q;
	class_t                class_q;
	logic [ID_BITS-1:0]    id_q;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);

	assign stamp_diff = dog_stamp - cat_stamp;
	// With one class empty the other is chosen; equal stamps go to the cat.
	assign dog_older  = cat_stat.empty || (!dog_stat.empty && stamp_diff[STAMP_BITS-1]);

	// Command decode: chain controls and the result of this request.
	always_comb begin
		dog_ctrl   = '0;
		cat_ctrl   = '0;
		enq        = 1'b0;
		res_status = ST_OK;
		res_class  = CLS_NONE;
		res_id     = '0;
		unique case (cmd)
			CMD_ENQ_DOG: begin
				enq = 1'b1;
				if (dog_stat.full) begin
					res_status = ST_FULL;
				end else begin
					dog_ctrl.push = take;
					res_class     = CLS_DOG;
				end
			end
			CMD_ENQ_CAT: begin
				enq = 1'b1;
				if (cat_stat.full) begin
					res_status = ST_FULL;
				end else begin
					cat_ctrl.push = take;
					res_class     = CLS_CAT;
				end
			end
			CMD_DEQ_ANY: begin
				priority if (dog_stat.empty && cat_stat.empty) begin
					res_status = ST_EMPTY;
				end else if (dog_older) begin
					dog_ctrl.pop = take;
					res_class    = CLS_DOG;
					res_id       = dog_id;
				end else begin
					cat_ctrl.pop = take;
					res_class    = CLS_CAT;
					res_id       = cat_id;
				end
			end
			CMD_DEQ_DOG: begin
				if (dog_stat.empty) begin
					res_status = ST_EMPTY;
				end else begin
					dog_ctrl.pop = take;
					res_class    = CLS_DOG;
					res_id       = dog_id;
				end
			end
			CMD_DEQ_CAT: begin
				if (cat_stat.empty) begin
					res_status = ST_EMPTY;
				end else begin
					cat_ctrl.pop = take;
					res_class    = CLS_CAT;
					res_id       = cat_id;
				end
			end
			default: begin
				// Unused codes: nothing changes and success with no class is reported.
			end
		endcase
	end

	// The shared arrival counter moves on every enqueue, even a dropped one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_q <= '0;
		end else if (take && enq) begin
			arrival_q <= arrival_q + STAMP_BITS'(1);
		end
	end

	toq_chain #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.STAMP_BITS (STAMP_BITS)
	) u_dog (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (dog_ctrl),
		.new_id    (s_tdata),
		.new_stamp (arrival_q),
		.head_id   (dog_id),
		.head_stamp(dog_stamp),
		.stat      (dog_stat)
	);

	toq_chain #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.STAMP_BITS (STAMP_BITS)
	) u_cat (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (cat_ctrl),
		.new_id    (s_tdata),
		.new_stamp (arrival_q),
		.head_id   (cat_id),
		.head_stamp(cat_stamp),
		.stat      (cat_stat)
	);

	// Output register: holds a result until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= res_status;
			class_q  <= res_class;
			id_q     <= res_id;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = id_q;
	assign m_tuser  = {class_q, status_q};

endmodule
